FILE: rtl/core/pil_pkg.sv
`default_nettype none

package pil_pkg;

  // List capacity and the widths that follow from it
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > 7) ? CNT_W : 7;

  // Fixed field widths
  localparam int REQ_W  = 2;
  localparam int POS_W  = 8;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int OUT_W  = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_GET    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_FIND   = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FETCH,
    S_REM_CAP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SCAN_RD,
    S_SCAN_CMP
  } state_t;

  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_INIT,
    PTR_INC,
    PTR_DEC
  } ptr_op_t;

  typedef enum logic [1:0] {
    RD_PTR,
    RD_PTR_DEC,
    RD_PTR_INC,
    RD_POS
  } rd_sel_t;

  typedef enum logic {
    WR_SHIFT,
    WR_PUT
  } wr_sel_t;

  typedef enum logic [1:0] {
    VAL_ZERO,
    VAL_HOLD,
    VAL_RDATA
  } val_src_t;

  // Controller to datapath
  typedef struct packed {
    logic     load;
    ptr_op_t  ptr_op;
    rd_sel_t  rd_sel;
    logic     wr_en;
    wr_sel_t  wr_sel;
    logic     cap_read;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     finish;
    status_t  fin_status;
    val_src_t fin_val;
    logic     fin_found;
  } pil_cmd_t;

  // Datapath to controller
  typedef struct packed {
    req_t req;
    logic full;
    logic pos_valid;
    logic ins_more;
    logic rem_more;
    logic scan_end;
    logic match;
  } pil_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/pil_ctrl.sv
`default_nettype none

module pil_ctrl
  import pil_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire pil_stat_t stat,
  output pil_cmd_t       cmd,
  output logic           busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (stat.req)
          REQ_INSERT: state_next = stat.full ? S_IDLE : S_SHIFT_RD;
          REQ_GET:    state_next = stat.pos_valid ? S_FETCH : S_IDLE;
          REQ_REMOVE: state_next = stat.pos_valid ? S_REM_CAP : S_IDLE;
          REQ_FIND:   state_next = S_SCAN_RD;
          default:    state_next = S_IDLE;
        endcase
      end
      S_FETCH:   state_next = S_IDLE;
      S_REM_CAP: state_next = S_SHIFT_RD;
      S_SHIFT_RD: begin
        if (stat.req == REQ_INSERT) begin
          state_next = stat.ins_more ? S_SHIFT_WR : S_IDLE;
        end else begin
          state_next = stat.rem_more ? S_SHIFT_WR : S_IDLE;
        end
      end
      S_SHIFT_WR: state_next = S_SHIFT_RD;
      S_SCAN_RD:  state_next = stat.scan_end ? S_IDLE : S_SCAN_CMP;
      S_SCAN_CMP: state_next = stat.match ? S_IDLE : S_SCAN_RD;
      default:    state_next = S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd            = '0;
    cmd.ptr_op     = PTR_HOLD;
    cmd.rd_sel     = RD_PTR;
    cmd.wr_sel     = WR_SHIFT;
    cmd.fin_status = ST_OK;
    cmd.fin_val    = VAL_ZERO;
    unique case (state)
      S_IDLE: begin
        cmd.load = start;
      end
      S_DECODE: begin
        cmd.rd_sel = RD_POS;
        unique case (stat.req)
          REQ_INSERT: begin
            if (stat.full) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_FULL;
            end else begin
              cmd.ptr_op = PTR_INIT;
            end
          end
          REQ_GET: begin
            if (!stat.pos_valid) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_RANGE;
            end
          end
          REQ_REMOVE: begin
            if (!stat.pos_valid) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_RANGE;
            end else begin
              cmd.ptr_op = PTR_INIT;
            end
          end
          REQ_FIND: begin
            cmd.ptr_op = PTR_INIT;
          end
          default: ;
        endcase
      end
      S_FETCH: begin
        cmd.finish  = 1'b1;
        cmd.fin_val = VAL_RDATA;
      end
      S_REM_CAP: begin
        cmd.cap_read = 1'b1;
      end
      S_SHIFT_RD: begin
        if (stat.req == REQ_INSERT) begin
          if (stat.ins_more) begin
            cmd.rd_sel = RD_PTR_DEC;
          end else begin
            // gap is open: drop the new value in
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_PUT;
            cmd.cnt_inc = 1'b1;
            cmd.finish  = 1'b1;
          end
        end else begin
          if (stat.rem_more) begin
            cmd.rd_sel = RD_PTR_INC;
          end else begin
            cmd.cnt_dec = 1'b1;
            cmd.finish  = 1'b1;
            cmd.fin_val = VAL_HOLD;
          end
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_SHIFT;
        cmd.ptr_op = (stat.req == REQ_INSERT) ? PTR_DEC : PTR_INC;
      end
      S_SCAN_RD: begin
        cmd.rd_sel = RD_PTR;
        if (stat.scan_end) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_NOT_FOUND;
        end
      end
      S_SCAN_CMP: begin
        if (stat.match) begin
          cmd.finish    = 1'b1;
          cmd.fin_found = 1'b1;
        end else begin
          cmd.ptr_op = PTR_INC;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/pil_datapath.sv
`default_nettype none

module pil_datapath
  import pil_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire pil_cmd_t                 cmd,
  input  wire logic        [REQ_W-1:0]  req_type,
  input  wire logic signed [POS_W-1:0]  position,
  input  wire logic signed [VAL_W-1:0]  data_value,
  output pil_stat_t                     stat,
  output logic                          done,
  output logic signed      [VAL_W-1:0]  read_value,
  output logic signed      [OUT_W-1:0]  found_index,
  output logic             [STAT_W-1:0] status,
  output logic             [OUT_W-1:0]  list_size
);

  // Request registers
  req_t             req_q;
  logic [POS_W-1:0] pos_q;
  logic [VAL_W-1:0] val_q;

  // Walk pointer, entry count, captured values
  logic [CNT_W-1:0] ptr;
  logic [CNT_W-1:0] ptr_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [VAL_W-1:0] hold;
  logic [VAL_W-1:0] rdata;

  // List storage
  logic [VAL_W-1:0] mem [CAPACITY];
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] waddr;
  logic [VAL_W-1:0] wdata;

  logic [CMP_W-1:0] pos_u;
  logic [CMP_W-1:0] cnt_u;
  logic             pos_neg;
  logic             pos_zero;
  logic [CNT_W-1:0] at;
  logic [CNT_W-1:0] ptr_inc;
  logic [CNT_W-1:0] ptr_dec;
  logic [CNT_W:0]   ptr_inc_w;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req_t'(req_type);
      pos_q <= position;
      val_q <= data_value;
    end
  end

  // Position decode against the current size
  assign pos_u    = CMP_W'(pos_q[POS_W-2:0]);
  assign cnt_u    = CMP_W'(count);
  assign pos_neg  = pos_q[POS_W-1];
  assign pos_zero = (pos_q == '0);

  always_comb begin
    if (!pos_neg && (pos_u >= cnt_u)) begin
      at = count;
    end else if (pos_neg || pos_zero) begin
      at = '0;
    end else begin
      at = CNT_W'(pos_u);
    end
  end

  assign ptr_inc   = ptr + 1'b1;
  assign ptr_dec   = ptr - 1'b1;
  assign ptr_inc_w = (CNT_W + 1)'(ptr) + 1'b1;

  always_comb begin
    stat.req       = req_q;
    stat.full      = (count == CNT_W'(CAPACITY));
    stat.pos_valid = !pos_neg && (pos_u < cnt_u);
    stat.ins_more  = (ptr > at);
    stat.rem_more  = (ptr_inc_w < (CNT_W + 1)'(count));
    stat.scan_end  = (ptr == count);
    stat.match     = (rdata == val_q);
  end

  // Pointer
  always_comb begin
    unique case (cmd.ptr_op)
      PTR_HOLD: ptr_next = ptr;
      PTR_INIT: begin
        unique case (req_q)
          REQ_INSERT: ptr_next = count;
          REQ_REMOVE: ptr_next = CNT_W'(pos_u);
          default:    ptr_next = '0;
        endcase
      end
      PTR_INC: ptr_next = ptr_inc;
      PTR_DEC: ptr_next = ptr_dec;
      default: ptr_next = ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
  end

  // Entry count
  always_comb begin
    count_next = count;
    if (cmd.cnt_inc) begin
      count_next = count + 1'b1;
    end else if (cmd.cnt_dec) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Memory addressing
  always_comb begin
    unique case (cmd.rd_sel)
      RD_PTR:     raddr = ptr[IDX_W-1:0];
      RD_PTR_DEC: raddr = ptr_dec[IDX_W-1:0];
      RD_PTR_INC: raddr = ptr_inc[IDX_W-1:0];
      RD_POS:     raddr = pos_u[IDX_W-1:0];
      default:    raddr = ptr[IDX_W-1:0];
    endcase
    if (cmd.wr_sel == WR_PUT) begin
      waddr = at[IDX_W-1:0];
      wdata = val_q;
    end else begin
      waddr = ptr[IDX_W-1:0];
      wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_read) begin
      hold <= rdata;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      unique case (cmd.fin_val)
        VAL_ZERO:  read_value <= '0;
        VAL_HOLD:  read_value <= hold;
        VAL_RDATA: read_value <= rdata;
        default:   read_value <= '0;
      endcase
      found_index <= cmd.fin_found ? OUT_W'(ptr) : '1;
      status      <= cmd.fin_status;
      list_size   <= OUT_W'(count_next);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/positional_integer_list.sv
// Bounded ordered list of signed 32-bit values, CAPACITY entries deep.
// Command channel: a request (req_type, position, data_value) transfers at
// a rising edge with start high and busy low. Insert, get, remove and find
// are served one at a time; busy stays high until the request completes.
// Result channel: done is high for exactly one cycle with read_value,
// found_index, status and list_size valid; the receiver cannot stall it,
// and a new request may be issued in that same cycle.
// Out-of-range get/remove and an insert into a full list finish in the decode
// state; get reads its entry and finishes; insert shifts the entries above its
// slot up, remove captures its entry and shifts those above it down, and find
// scans from slot zero until a match or the end of the list.
// The entries sit in a single-port-write, registered-read memory, so each
// entry moved or compared takes a read state and then a write or compare state.
// Synchronous reset empties the list (entry count to zero) and leaves the
// controller idle; memory contents are not cleared and need not be.
`default_nettype none

module positional_integer_list
  import pil_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic        [REQ_W-1:0]  req_type,
  input  wire logic signed [POS_W-1:0]  position,
  input  wire logic signed [VAL_W-1:0]  data_value,
  output logic                          done,
  output logic signed      [VAL_W-1:0]  read_value,
  output logic signed      [OUT_W-1:0]  found_index,
  output logic             [STAT_W-1:0] status,
  output logic             [OUT_W-1:0]  list_size
);

  pil_cmd_t  cmd;
  pil_stat_t stat;

  pil_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  pil_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .req_type    (req_type),
    .position    (position),
    .data_value  (data_value),
    .stat        (stat),
    .done        (done),
    .read_value  (read_value),
    .found_index (found_index),
    .status      (status),
    .list_size   (list_size)
  );

endmodule

`default_nettype wire

FILE: rtl/core/pil_checker.sv
`default_nettype none

module pil_checker
  import pil_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     start,
  input wire logic                     busy,
  input wire logic                     done,
  input wire logic signed [VAL_W-1:0]  read_value,
  input wire logic signed [OUT_W-1:0]  found_index,
  input wire logic        [STAT_W-1:0] status,
  input wire logic        [OUT_W-1:0]  list_size
);

  // A result always leaves the block ready for the next transfer
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  // An accepted request occupies the block in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("request accepted but block not busy");

  // A refused insert only happens at capacity
  a_full_size: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_FULL)) |-> (list_size == OUT_W'(CAPACITY)))
    else $error("full status below capacity");

  // Failed requests return no value and no index
  a_miss_empty: assert property (@(posedge clk) disable iff (rst)
    (done && ((status == ST_RANGE) || (status == ST_NOT_FOUND) || (status == ST_FULL)))
      |-> ((read_value == '0) && (found_index == '1)))
    else $error("failed request carries a value or index");

endmodule

bind positional_integer_list pil_checker u_pil_checker (.*);

`default_nettype wire

FILE: verif/pil_list_book_pkg.sv
`timescale 1ns / 100ps

package pil_list_book_pkg;
  import pil_pkg::*;

  // One reply of the list block, field by field
  typedef struct {
    logic signed [VAL_W-1:0]  read_value;
    logic signed [OUT_W-1:0]  found_index;
    status_t                  status;
    logic        [OUT_W-1:0]  list_size;
  } list_reply_t;

  // Shadow copy of the list plus the replies still owed by the block
  class list_book;
    logic signed [VAL_W-1:0] slots [CAPACITY];
    int                      count;
    list_reply_t             replies_due [$];
    int                      errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function int size();
      return count;
    endfunction

    function logic signed [VAL_W-1:0] value_at(int idx);
      return slots[idx];
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    // Apply one accepted request to the shadow list and queue its reply
    function void note_request(req_t req, logic signed [POS_W-1:0] pos,
                               logic signed [VAL_W-1:0] val);
      list_reply_t r;
      int          p;
      int          at;
      bit          in_list;
      p       = pos;
      in_list = (p >= 0) && (p < count);
      r.read_value  = '0;
      r.found_index = '1;
      r.status      = ST_OK;
      case (req)
        REQ_INSERT: begin
          if (count >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            // past the end appends, below one prepends
            if (p >= count) at = count;
            else if (p < 1) at = 0;
            else at = p;
            for (int i = count; i > at; i--) slots[i] = slots[i-1];
            slots[at] = val;
            count++;
          end
        end
        REQ_GET: begin
          if (in_list) r.read_value = slots[p];
          else r.status = ST_RANGE;
        end
        REQ_REMOVE: begin
          if (in_list) begin
            r.read_value = slots[p];
            for (int i = p; i + 1 < count; i++) slots[i] = slots[i+1];
            count--;
          end else begin
            r.status = ST_RANGE;
          end
        end
        default: begin
          // scan downward so the last hit is the lowest index
          r.status = ST_NOT_FOUND;
          for (int i = count - 1; i >= 0; i--) begin
            if (slots[i] == val) begin
              r.found_index = OUT_W'(i);
              r.status      = ST_OK;
            end
          end
        end
      endcase
      r.list_size = OUT_W'(count);
      replies_due.push_back(r);
    endfunction

    // Compare one reply transfer with the oldest owed reply
    function void check_result(logic signed [VAL_W-1:0] rv, logic signed [OUT_W-1:0] fi,
                               logic [STAT_W-1:0] st, logic [OUT_W-1:0] ls);
      list_reply_t e;
      if (replies_due.size() == 0) begin
        $error("reply with no request outstanding");
        errors++;
        return;
      end
      e = replies_due.pop_front();
      if (rv !== e.read_value) begin
        $error("read_value: expected %0d, got %0d", e.read_value, rv);
        errors++;
      end
      if (fi !== e.found_index) begin
        $error("found_index: expected %0d, got %0d", e.found_index, fi);
        errors++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (ls !== e.list_size) begin
        $error("list_size: expected %0d, got %0d", e.list_size, ls);
        errors++;
      end
    endfunction
  endclass

endpackage

FILE: verif/tb_positional_integer_list.sv
`timescale 1ns / 100ps

module tb_positional_integer_list;
  import pil_pkg::*;
  import pil_list_book_pkg::*;

  localparam int RUN_LIMIT = 300000;

  typedef enum {MIX_EVEN, MIX_FILL, MIX_DRAIN} mix_t;

  logic                     clk        = 1'b0;
  logic                     rst        = 1'b1;
  logic                     start      = 1'b0;
  logic        [REQ_W-1:0]  req_type   = '0;
  logic signed [POS_W-1:0]  position   = '0;
  logic signed [VAL_W-1:0]  data_value = '0;
  logic                     busy;
  logic                     done;
  logic signed [VAL_W-1:0]  read_value;
  logic signed [OUT_W-1:0]  found_index;
  logic        [STAT_W-1:0] status;
  logic        [OUT_W-1:0]  list_size;

  list_book                 book;
  logic signed [VAL_W-1:0]  value_pool [8];
  int                       cycles = 0;

  positional_integer_list DUT (clk, rst, start, busy, req_type, position, data_value,
                               done, read_value, found_index, status, list_size);

  always #1 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("tb_positional_integer_list: errors");
      $finish;
    end
  end

  // Reply monitor: done marks a one-cycle transfer
  always @(posedge clk) begin
    if (!rst && done) book.check_result(read_value, found_index, status, list_size);
  end

  // Present a request and hold it until the transfer; start is left high
  task automatic send_request(input req_t r, input logic signed [POS_W-1:0] p,
                              input logic signed [VAL_W-1:0] v);
    start      <= 1'b1;
    req_type   <= r;
    position   <= p;
    data_value <= v;
    do @(posedge clk); while (busy);
    book.note_request(r, p, v);
  endtask

  task automatic pause_sender(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // At least one edge passes, so start is never driven twice in one step
  task automatic wait_for_replies();
    start <= 1'b0;
    do @(posedge clk); while (book.pending() != 0);
  endtask

  // Random request shaped by the current mix
  task automatic random_request(input mix_t mix);
    req_t                    r;
    logic signed [POS_W-1:0] p;
    logic signed [VAL_W-1:0] v;
    int                      n;
    int                      roll;
    int                      w_ins;
    int                      w_get;
    int                      w_rem;
    n = book.size();
    case (mix)
      MIX_FILL: begin
        w_ins = 85; w_get = 5; w_rem = 0;
      end
      MIX_DRAIN: begin
        w_ins = 10; w_get = 15; w_rem = 60;
      end
      default: begin
        w_ins = 30; w_get = 25; w_rem = 20;
      end
    endcase
    roll = $urandom_range(99);
    if (roll < w_ins) r = REQ_INSERT;
    else if (roll < w_ins + w_get) r = REQ_GET;
    else if (roll < w_ins + w_get + w_rem) r = REQ_REMOVE;
    else r = REQ_FIND;
    // position: mostly inside, some at the edges, some anywhere
    roll = $urandom_range(99);
    if (roll < 15) begin
      p = POS_W'($urandom);
    end else if (roll < 30) begin
      case ($urandom_range(3))
        0: p = POS_W'(n);
        1: p = POS_W'(n - 1);
        2: p = -1;
        default: p = 0;
      endcase
    end else begin
      p = POS_W'($urandom_range(n > 0 ? n - 1 : 0));
    end
    // value: reuse pool and list contents so finds hit and duplicates occur
    roll = $urandom_range(99);
    if (r == REQ_FIND && n > 0 && roll < 40) v = book.value_at($urandom_range(n - 1));
    else if (roll < 70) v = value_pool[$urandom_range(7)];
    else v = $urandom;
    send_request(r, p, v);
  endtask

  initial begin
    mix_t mix;
    int   idle_pct;
    book = new();
    foreach (value_pool[i]) value_pool[i] = $urandom;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 0;
    value_pool[3] = -1;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty list: out of range and not found
    send_request(REQ_GET,    0, 0);
    send_request(REQ_REMOVE, 0, 0);
    send_request(REQ_FIND,   0, 0);
    // Extreme positions and values, prepend, append, middle
    send_request(REQ_INSERT, -128, 32'h8000_0000);
    send_request(REQ_INSERT,  127, 32'h7FFF_FFFF);
    send_request(REQ_INSERT,    1, 0);
    send_request(REQ_INSERT,    0, -1);
    send_request(REQ_INSERT,    4, 32'h5A5A_5A5A);
    send_request(REQ_INSERT,   -1, 1);
    send_request(REQ_GET,  0, 0);
    send_request(REQ_GET,  5, 0);
    send_request(REQ_GET,  6, 0);
    send_request(REQ_GET, -1, 0);
    send_request(REQ_FIND, 0, 32'h7FFF_FFFF);
    send_request(REQ_FIND, 0, 32'h1234_5678);
    // Duplicate value: find must report the first
    send_request(REQ_INSERT, 2, -1);
    send_request(REQ_FIND,   0, -1);
    send_request(REQ_REMOVE, 127, 0);
    send_request(REQ_REMOVE, 6, 0);
    send_request(REQ_REMOVE, 1, 0);
    // Drain to empty, last remove on a one-entry list
    while (book.size() > 0) send_request(REQ_REMOVE, 0, 0);
    send_request(REQ_GET, 0, 0);
    wait_for_replies();

    // Random segments; two fill segments back to back reach a full list
    for (int seg = 0; seg < 8; seg++) begin
      case (seg)
        1, 2, 6: mix = MIX_FILL;
        4, 5:    mix = MIX_DRAIN;
        default: mix = MIX_EVEN;
      endcase
      idle_pct = (seg >= 6) ? 0 : 30;
      if (seg == 4) wait_for_replies();
      for (int k = 0; k < 50; k++) begin
        random_request(mix);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) pause_sender($urandom_range(1, 13));
      end
    end

    wait_for_replies();
    repeat (8) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("tb_positional_integer_list: clean");
    end else begin
      $display("tb_positional_integer_list: errors");
    end
    $finish;
  end

endmodule
